// ===== rtl/mcer_pkg.sv =====
// mcer_pkg: shared widths, constants and types of the multi-channel echo ranger
// no dependencies; imported by every rtl file of the block
`default_nettype none
package mcer_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int CHANNELS_MAX = 16;
   localparam int ECHO_W       = 4;
   localparam int SEL_W        = 2;
   localparam int IDX_W        = $clog2(CHANNELS_MAX + 1);
   localparam int COUNT_W      = 12;
   localparam int PHASE_W      = 15;
   localparam int WEND_W       = 12;
   localparam int PERIOD_W     = 14;
   localparam int DIST_W       = 12;

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_END  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PING_PERIOD = 2'd1;

   localparam logic [WEND_W-1:0]   WINDOW_END_RST  = 12'd200;
   localparam logic [PERIOD_W-1:0] PING_PERIOD_RST = 14'd3000;

   localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

   // cm = count * 34000 / 60000 = count * 17 / 30 = ((count * 17) >> 1) / 15
   localparam int SOUND_NUM   = 34000;
   localparam int SOUND_DEN   = 60000;
   localparam int SCALE_NUM   = SOUND_NUM / 2000;
   localparam int HALF_W      = 16;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 17;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 17'd69906;
   localparam int PROD_W      = HALF_W + RECIP_W;

   typedef struct packed {
      logic step;
      logic clear;
      logic count_en;
      logic latch;
   } lane_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/mcer_req_if.sv =====
// mcer_req_if: input item channel (echo levels and channel select)
// depends on mcer_pkg
`default_nettype none
interface mcer_req_if import mcer_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ECHO_W-1:0] echo_levels;
   logic [SEL_W-1:0]  channel_select;

   modport source (output valid, output echo_levels, output channel_select, input ready);
   modport sink   (input valid, input echo_levels, input channel_select, output ready);
endinterface
`default_nettype wire

// ===== rtl/mcer_rsp_if.sv =====
// mcer_rsp_if: result item channel (trigger, latch flag, distance)
// depends on mcer_pkg
`default_nettype none
interface mcer_rsp_if import mcer_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              trigger_level;
   logic              results_latched;
   logic [DIST_W-1:0] distance_cm;

   modport source (output valid, output trigger_level, output results_latched,
                   output distance_cm, input ready);
   modport sink   (input valid, input trigger_level, input results_latched,
                   input distance_cm, output ready);
endinterface
`default_nettype wire

// ===== rtl/multi_channel_echo_ranger_core.sv =====
// Multi-channel echo ranger: one input item is one timer tick carrying the echo pin
// levels of all channels and a channel to report. A phase counter drives the ping
// cycle: the active-low trigger is low and all echo counters clear on phase zero,
// each channel counts ticks of high echo on phases 2 to window_end-1 (saturating at
// 4095), and the counts are latched at phase window_end; the phase wraps to zero
// after it passes ping_period. Every item yields one result item with the trigger
// level, a latch flag and the selected channel's latched count as count*17/30 cm.
// An item is taken every cycle unless the output pipeline stalls; its result is
// registered in the select stage and then in the reciprocal multiply stage.
// Registers window_end and ping_period are written through the csr_ port.
`default_nettype none
module multi_channel_echo_ranger_core import mcer_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   mcer_req_if.sink                   req_ch,
   mcer_rsp_if.source                 rsp_ch
);

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [WEND_W-1:0]   window_end_ff, window_end_in;
   logic [PERIOD_W-1:0] ping_period_ff, ping_period_in;
   lane_ctl_type        ctl;
   logic                take;
   logic                accept;
   logic [CHANNELS-1:0][COUNT_W-1:0] latched_next;

   assign accept     = req_ch.valid && take;
   assign req_ch.ready = take;

   always_comb begin
      ctl.step     = accept;
      ctl.clear    = (phase_ff == '0);
      ctl.count_en = (phase_ff > PHASE_W'(1)) && (phase_ff < PHASE_W'(window_end_ff));
      ctl.latch    = (phase_ff == PHASE_W'(window_end_ff));
      phase_in     = phase_ff;
      if (accept) begin
         if (phase_ff > PHASE_W'(ping_period_ff)) begin
            phase_in = '0;
         end else begin
            phase_in = phase_ff + 1'b1;
         end
      end
   end

   always_comb begin
      window_end_in  = window_end_ff;
      ping_period_in = ping_period_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_END:  window_end_in  = csr_write_data[WEND_W-1:0];
            CSR_PING_PERIOD: ping_period_in = csr_write_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= '0;
         window_end_ff  <= WINDOW_END_RST;
         ping_period_ff <= PING_PERIOD_RST;
      end else begin
         phase_ff       <= phase_in;
         window_end_ff  <= window_end_in;
         ping_period_ff <= ping_period_in;
      end
   end

   for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
      logic echo_bit;
      if (k < ECHO_W) begin : g_pin
         assign echo_bit = req_ch.echo_levels[k];
      end else begin : g_nopin
         assign echo_bit = 1'b0;
      end
      mcer_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .echo         (echo_bit),
         .latched_next (latched_next[k])
      );
   end

   mcer_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .take    (take),
      .counts  (latched_next),
      .sel     (req_ch.channel_select),
      .trig    (!ctl.clear),
      .latched (ctl.latch),
      .rsp     (rsp_ch)
   );

   a_latch_not_counting: assert property (@(posedge clock) disable iff (reset)
      !(ctl.latch && ctl.count_en))
      else $error("latch and count on the same phase");

   a_phase_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff > PHASE_W'(ping_period_ff))) |=> (phase_ff == '0))
      else $error("phase did not wrap past ping period");

   a_after_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && ctl.clear) |=> (phase_ff == PHASE_W'(1)))
      else $error("phase did not advance after trigger tick");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff))
      else $error("phase moved without an item");

endmodule
`default_nettype wire

// ===== rtl/mcer_lane.sv =====
// mcer_lane: one channel's saturating echo counter and latched count
// depends on mcer_pkg (lane_ctl_type, COUNT_W)
`default_nettype none
module mcer_lane import mcer_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lane_ctl_type       ctl,
   input  wire logic               echo,
   output logic [COUNT_W-1:0]      latched_next
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] latched_ff, latched_in;
   logic [COUNT_W-1:0] count_next;

   always_comb begin
      count_next = count_ff;
      if (ctl.clear) begin
         count_next = '0;
      end else if (ctl.count_en && echo && (count_ff != COUNT_MAX)) begin
         count_next = count_ff + 1'b1;
      end
      latched_next = ctl.latch ? count_next : latched_ff;
      count_in     = ctl.step ? count_next : count_ff;
      latched_in   = ctl.step ? latched_next : latched_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         latched_ff <= '0;
      end else begin
         count_ff   <= count_in;
         latched_ff <= latched_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mcer_merge.sv =====
// mcer_merge: picks the selected lane's latched count and scales it to cm
// two register stages with stall; depends on mcer_pkg and mcer_rsp_if
`default_nettype none
module mcer_merge import mcer_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   output logic                                 take,
   input  wire logic [CHANNELS-1:0][COUNT_W-1:0] counts,
   input  wire logic [SEL_W-1:0]                sel,
   input  wire logic                            trig,
   input  wire logic                            latched,
   mcer_rsp_if.source                           rsp
);

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_trig_ff, s1_latched_ff;
   logic [HALF_W-1:0] s1_half_ff;
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_trig_ff, s2_latched_ff;
   logic [DIST_W-1:0] s2_dist_ff;
   logic              s2_take;
   logic [COUNT_W-1:0] pick;
   logic [HALF_W:0]    scaled;
   logic [PROD_W-1:0]  prod;

   always_comb begin
      pick = '0;
      for (int k = 0; k < CHANNELS; k++) begin
         if (IDX_W'(sel) == IDX_W'(k)) begin
            pick = counts[k];
         end
      end
      scaled = (HALF_W + 1)'(pick) * (HALF_W + 1)'(SCALE_NUM);
      prod   = PROD_W'(s1_half_ff) * PROD_W'(RECIP_MULT);
   end

   assign s2_take = !s2_valid_ff || rsp.ready;
   assign take    = !s1_valid_ff || s2_take;

   assign s1_valid_in = take ? accept : s1_valid_ff;
   assign s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_trig_ff    <= trig;
         s1_latched_ff <= latched;
         s1_half_ff    <= scaled[HALF_W:1];
      end
      if (s2_take && s1_valid_ff) begin
         s2_trig_ff    <= s1_trig_ff;
         s2_latched_ff <= s1_latched_ff;
         s2_dist_ff    <= prod[RECIP_SHIFT +: DIST_W];
      end
   end

   assign rsp.valid           = s2_valid_ff;
   assign rsp.trigger_level   = s2_trig_ff;
   assign rsp.results_latched = s2_latched_ff;
   assign rsp.distance_cm     = s2_dist_ff;

   a_take_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> take)
      else $error("merge stage refuses an item while empty");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_take && !accept) |=> !s1_valid_ff && s2_valid_ff)
      else $error("first stage item not handed on");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rsp.ready && s1_valid_ff) |-> !take)
      else $error("item taken while both stages are full and stalled");

endmodule
`default_nettype wire
